// ===== rtl/core/ssp_pkg.sv =====
// Package: shared types, constants and helpers for sprite projection
`timescale 1ns / 1ps
`default_nettype none
package ssp_pkg;
    localparam int DefScreenWidth  = 1024;
    localparam int DefScreenHeight = 768;
    localparam int CfgIdxW         = 3;
    localparam int CfgDataW        = 32;
    localparam logic [CfgIdxW-1:0] CFG_CAM_POS_X   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CAM_POS_Y   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_VIEW_DIR_X  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_VIEW_DIR_Y  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CAM_PLANE_X = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_CAM_PLANE_Y = 3'd5;
    localparam logic signed [31:0] NearLimit = 32'sd655;

    typedef struct packed {
        logic signed [31:0] sprite_x;
        logic signed [31:0] sprite_y;
    } t_in_item;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] center_col;
        logic        [15:0] span_size;
        logic        [8:0]  top_row;
        logic        [9:0]  bottom_row;
        logic        [14:0] left_col;
        logic signed [15:0] right_col;
    } t_out_item;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return 32'sh7FFFFFFF;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ssp_if.sv =====
// Interface: valid/ready channel carrying one payload
`timescale 1ns / 1ps
`default_nettype none
interface ssp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned
`timescale 1ns / 1ps
`default_nettype none
module ssp_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);
    // stage k holds quotient/remaining-numerator shift register and remainder
    logic [NW-1:0] r_q   [1:NW];
    logic [DW:0]   r_rem [1:NW];
    logic [DW-1:0] r_den [1:NW];
    logic [TW-1:0] r_tag [1:NW];
    logic          r_vld [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0] w_q;
        logic [DW:0]   w_rem;
        logic [DW-1:0] w_den;
        logic [TW-1:0] w_tag;
        logic          w_vld;
        logic [DW+1:0] n_trial;
        logic [DW:0]   n_shift;
        if (k == 0) begin : g_head
            assign w_q   = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
            assign w_vld = i_valid;
        end else begin : g_body
            assign w_q   = r_q[k];
            assign w_rem = r_rem[k];
            assign w_den = r_den[k];
            assign w_tag = r_tag[k];
            assign w_vld = r_vld[k];
        end
        always_comb begin
            n_shift = {w_rem[DW-1:0], w_q[NW-1]};
            n_trial = {1'b0, n_shift} - {2'b00, w_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= w_vld;
            end
            if (i_en) begin
                r_den[k+1] <= w_den;
                r_tag[k+1] <= w_tag;
                if (!n_trial[DW+1]) begin
                    r_rem[k+1] <= n_trial[DW:0];
                    r_q[k+1]   <= {w_q[NW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_shift;
                    r_q[k+1]   <= {w_q[NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_q[NW];
    assign o_tag   = r_tag[NW];
endmodule
`default_nettype wire

// ===== rtl/core/sprite_screen_projection.sv =====
// Top level: sprite world position to screen span, deep pipeline
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  - s_in (sink) transfers one sprite world position (Q16.16 x, y).
//  - m_out (source) transfers one projection result per input, in order.
//  - Camera registers are written on i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
//    them only while idle, the block does not check this; unknown indexes are ignored.
// Throughput: one sprite per cycle while the receiver does not stall. From the
// input transfer to the result transfer the pipe holds three front stages, the
// 48-stage transform dividers, two stages, the 48-stage center and size
// dividers, one stage and the output register.
// The whole pipe advances together under one enable; when the receiver
// stalls with a result waiting in the output register, every stage holds,
// and s_in.ready drops. s_in.ready is !m_out.valid || m_out.ready, so the
// receiver's ready reaches the input combinationally.
// Reset: camera returns to pos (0,0), dir (1,0), plane (0,0.66); all valid
// bits clear, so no result is in flight after reset.
// Invisible sprites (zero determinant or depth at most 0.01) give visible=0
// and every other field zero.
module sprite_screen_projection #(
    parameter int SCREEN_WIDTH  = ssp_pkg::DefScreenWidth,
    parameter int SCREEN_HEIGHT = ssp_pkg::DefScreenHeight
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ssp_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [ssp_pkg::CfgDataW-1:0]  i_cfg_data,
    ssp_if.sink                                s_in,
    ssp_if.source                              m_out
);
    import ssp_pkg::*;

    localparam int HalfW = SCREEN_WIDTH / 2;
    localparam int HalfH = SCREEN_HEIGHT / 2;

    // ---------------- configuration ----------------
    logic signed [31:0] r_pos_x, r_pos_y, r_dir_x, r_dir_y, r_pln_x, r_pln_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_dir_x <= 32'sd65536;
            r_dir_y <= '0;
            r_pln_x <= '0;
            r_pln_y <= 32'sd43254;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAM_POS_X:   r_pos_x <= i_cfg_data;
                CFG_CAM_POS_Y:   r_pos_y <= i_cfg_data;
                CFG_VIEW_DIR_X:  r_dir_x <= i_cfg_data;
                CFG_VIEW_DIR_Y:  r_dir_y <= i_cfg_data;
                CFG_CAM_PLANE_X: r_pln_x <= i_cfg_data;
                CFG_CAM_PLANE_Y: r_pln_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Determinant depends only on config; computed in two registered steps.
    logic signed [63:0] r_dp1, r_dp2;
    logic signed [31:0] r_det;
    always_ff @(posedge i_clk) begin
        r_dp1 <= r_pln_x * r_dir_y;
        r_dp2 <= r_dir_x * r_pln_y;
        r_det <= sat32((66'(r_dp1) - 66'(r_dp2)) >>> 16);
    end

    // ---------------- pipeline control ----------------
    logic       w_en;     // global advance
    logic       r_ob_v;   // output register valid
    t_out_item  r_ob;
    assign w_en       = !r_ob_v || m_out.ready;
    assign s_in.ready = w_en;

    logic w_acc;
    assign w_acc = s_in.valid && s_in.ready;

    // S1: offsets
    logic r1_v;
    logic signed [31:0] r1_dx, r1_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= w_acc;
        if (w_en) begin
            r1_dx <= sat32(66'(s_in.data.sprite_x) - 66'(r_pos_x));
            r1_dy <= sat32(66'(s_in.data.sprite_y) - 66'(r_pos_y));
        end
    end

    // S2: four products
    logic r2_v;
    logic signed [63:0] r2_a, r2_b, r2_c, r2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            r2_a <= r_dir_y * r1_dx;
            r2_b <= r_dir_x * r1_dy;
            r2_c <= r_pln_x * r1_dy;
            r2_d <= r_pln_y * r1_dx;
        end
    end

    // S3: numerators, sign/magnitude prep for the dividers
    logic r3_v;
    logic signed [31:0] r3_nx, r3_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_nx <= sat32((66'(r2_a) - 66'(r2_b)) >>> 16);
            r3_ny <= sat32((66'(r2_c) - 66'(r2_d)) >>> 16);
        end
    end

    // Transform dividers: |n|*2^16 / |det|, 48-bit numerator
    logic [47:0] w_nxm, w_nym, w_q_tx, w_q_ty;
    logic [31:0] w_detm;
    logic        w_dz;
    always_comb begin
        w_nxm  = r3_nx[31] ? 48'(-33'(r3_nx)) << 16 : 48'(r3_nx) << 16;
        w_nym  = r3_ny[31] ? 48'(-33'(r3_ny)) << 16 : 48'(r3_ny) << 16;
        w_detm = r_det[31] ? 32'(-33'(r_det)) : r_det;
        w_dz   = (r_det == '0);
    end
    // tag: zero-det, sign tx, sign ty, spare
    logic [3:0] w_tag1, w_tag_tx, w_tag_ty;
    logic       w_v_tx, w_v_ty;
    assign w_tag1 = {w_dz, r3_nx[31] ^ r_det[31], r3_ny[31] ^ r_det[31], 1'b0};
    ssp_div #(.NW(48), .DW(32), .TW(4)) u_div_tx (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r3_v),
        .i_num(w_nxm), .i_den(w_dz ? 32'd1 : w_detm), .i_tag(w_tag1),
        .o_valid(w_v_tx), .o_quo(w_q_tx), .o_tag(w_tag_tx));
    ssp_div #(.NW(48), .DW(32), .TW(4)) u_div_ty (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r3_v),
        .i_num(w_nym), .i_den(w_dz ? 32'd1 : w_detm), .i_tag(w_tag1),
        .o_valid(w_v_ty), .o_quo(w_q_ty), .o_tag(w_tag_ty));

    // S4: signed, saturated tx/ty and visibility
    logic r4_v, r4_vis, r4_dz;
    logic signed [31:0] r4_tx, r4_ty;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= w_v_tx;
        if (w_en) begin
            r4_tx  <= sat32(w_tag_tx[2] ? -66'(w_q_tx) : 66'(w_q_tx));
            r4_ty  <= sat32(w_tag_ty[1] ? -66'(w_q_ty) : 66'(w_q_ty));
            r4_dz  <= w_tag_tx[3];
        end
    end
    always_comb r4_vis = !r4_dz && (r4_ty > NearLimit);

    // S5: center numerator product, size numerator; 2nd divider pair
    // center = trunc(HalfW*(ty+tx)/ty), size = trunc(H*2^16/ty)
    logic r5_v, r5_vis, r5_cneg;
    logic [47:0] r5_cm;
    logic [31:0] r5_ty;
    logic signed [33:0] w_s;
    logic signed [47:0] w_cn;
    always_comb begin
        w_s  = 34'(r4_ty) + 34'(r4_tx);
        w_cn = 48'(w_s) * 48'(HalfW);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
        if (w_en) begin
            r5_vis  <= r4_vis;
            r5_cneg <= w_cn[47];
            r5_cm   <= w_cn[47] ? -w_cn : w_cn;
            r5_ty   <= r4_vis ? r4_ty : 32'd1;
        end
    end
    logic [47:0] w_q_c, w_q_s;
    logic [1:0]  w_tag_c, w_tag_s;
    logic        w_v_c, w_v_s;
    ssp_div #(.NW(48), .DW(32), .TW(2)) u_div_c (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r5_v),
        .i_num(r5_cm), .i_den(r5_ty), .i_tag({r5_vis, r5_cneg}),
        .o_valid(w_v_c), .o_quo(w_q_c), .o_tag(w_tag_c));
    ssp_div #(.NW(48), .DW(32), .TW(2)) u_div_s (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r5_v),
        .i_num(48'(SCREEN_HEIGHT) << 16), .i_den(r5_ty), .i_tag(2'b00),
        .o_valid(w_v_s), .o_quo(w_q_s), .o_tag(w_tag_s));

    // S6: signed center, size, half size
    logic r6_v, r6_vis;
    logic signed [49:0] r6_c, r6_h, r6_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_en) r6_v <= w_v_c;
        if (w_en) begin
            r6_vis <= w_tag_c[1];
            r6_c   <= w_tag_c[0] ? -50'(w_q_c) : 50'(w_q_c);
            r6_sz  <= 50'(w_q_s);
            r6_h   <= 50'(w_q_s >> 1);
        end
    end

    // S7: bounds, clamp, saturate into output register
    t_out_item n_ob;
    logic signed [49:0] w_top, w_bot, w_lft, w_rgt;
    always_comb begin
        w_top = 50'(HalfH) - r6_h;
        w_bot = 50'(HalfH) + r6_h;
        w_lft = r6_c - r6_h;
        w_rgt = r6_c + r6_h;
        if (w_top < 0) w_top = '0;
        if (w_bot >= 50'(SCREEN_HEIGHT)) w_bot = 50'(SCREEN_HEIGHT - 1);
        if (w_lft < 0) w_lft = '0;
        if (w_rgt >= 50'(SCREEN_WIDTH)) w_rgt = 50'(SCREEN_WIDTH - 1);
        n_ob = '0;
        if (r6_vis) begin
            n_ob.visible    = 1'b1;
            n_ob.center_col = (r6_c > 50'sd32767) ? 16'sh7FFF :
                              (r6_c < -50'sd32768) ? 16'sh8000 : r6_c[15:0];
            n_ob.span_size  = (r6_sz > 50'sd65535) ? 16'hFFFF : r6_sz[15:0];
            n_ob.top_row    = w_top[8:0];
            n_ob.bottom_row = w_bot[9:0];
            n_ob.left_col   = (w_lft > 50'sd32767) ? 15'h7FFF : w_lft[14:0];
            n_ob.right_col  = (w_rgt < -50'sd32768) ? 16'sh8000 : w_rgt[15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ob_v <= 1'b0;
        else if (w_en) r_ob_v <= r6_v;
        if (w_en) r_ob <= n_ob;
    end
    assign m_out.valid = r_ob_v;
    assign m_out.data  = r_ob;

    // unused tags from lockstep dividers
    logic w_unused;
    assign w_unused = ^{w_v_ty, w_tag_ty[3], w_tag_ty[2], w_tag_ty[0], w_tag_tx[1],
                        w_tag_tx[0], w_v_s, w_tag_s};

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_v && !m_out.ready |=> r_ob_v && $stable(r_ob))
        else $error("result changed under stall");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v_tx == w_v_ty && w_v_c == w_v_s)
        else $error("divider pair out of step");
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_v && !r_ob.visible |-> r_ob.span_size == '0 && r_ob.center_col == '0)
        else $error("invisible result not zeroed");
endmodule
`default_nettype wire

// ===== sim/sprite_screen_projection_tb.sv =====
// Testbench: sprite projection checked per transfer against a Q16.16 predictor
`timescale 1ns / 1ps
`default_nettype none
module sprite_screen_projection_tb;
    import ssp_pkg::*;

    localparam int ScrW       = 1024;
    localparam int ScrH       = 768;
    localparam int RandItems  = 700;
    localparam int QuietTail  = 80;     // last transfers run with no idling
    localparam int DrainWait  = 150;    // pipe is 103 deep
    localparam int CycleLimit = 1000000;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_B = 3'd7;
    localparam logic signed [31:0] QOne = 32'sd65536;
    localparam logic signed [31:0] QMax = 32'sh7FFFFFFF;
    localparam logic signed [31:0] QMin = 32'sh80000000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    ssp_if #(.T(t_in_item))  in_ch ();
    ssp_if #(.T(t_out_item)) out_ch ();

    sprite_screen_projection u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    // Camera copy kept by the testbench, mirrors every register write.
    logic signed [31:0] cam_x, cam_y, dir_x, dir_y, pln_x, pln_y;

    t_out_item pending_proj[$];   // projections awaiting their output transfer
    int        errors;
    int        cycles;
    int        n_sent;
    int        n_seen;
    int        n_visible;
    bit        quiet;             // no idling on either side

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor, all arithmetic at full width then clamped like the block
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] clamp_q(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return QMax;
        if (v < -66'sd2147483648) return QMin;
        return v[31:0];
    endfunction

    // (a*b - c*d) in Q32.32, floored back to Q16.16
    function automatic logic signed [31:0] cross_q(input logic signed [31:0] a,
            input logic signed [31:0] b, input logic signed [31:0] c,
            input logic signed [31:0] d);
        logic signed [65:0] wa, wb, wc, wd, acc;
        wa = a; wb = b; wc = c; wd = d;
        acc = wa * wb - wc * wd;
        return clamp_q(acc >>> 16);
    endfunction

    function automatic logic signed [31:0] divide_q(input logic signed [31:0] num,
            input logic signed [31:0] den);
        longint n;
        longint d;
        n = longint'(num) * 65536;
        d = den;
        return clamp_q(66'(n / d));
    endfunction

    function automatic t_out_item project_sprite(input logic signed [31:0] sx,
            input logic signed [31:0] sy);
        t_out_item          r;
        logic signed [31:0] dx, dy, det, nx, ny, tx, ty;
        longint             center, span, half, top, bottom, left, right;
        r  = '0;
        dx = clamp_q(66'(longint'(sx) - longint'(cam_x)));
        dy = clamp_q(66'(longint'(sy) - longint'(cam_y)));
        det = cross_q(pln_x, dir_y, dir_x, pln_y);
        if (det == 0) return r;                 // singular camera
        nx = cross_q(dir_y, dx, dir_x, dy);
        ny = cross_q(pln_x, dy, pln_y, dx);
        tx = divide_q(nx, det);
        ty = divide_q(ny, det);
        if (ty <= NearLimit) return r;          // behind or too close
        center = (longint'(ScrW / 2) * (longint'(ty) + longint'(tx))) / longint'(ty);
        span   = (longint'(ScrH) * 65536) / longint'(ty);
        half   = span / 2;
        top    = ScrH / 2 - half;
        if (top < 0) top = 0;
        bottom = ScrH / 2 + half;
        if (bottom >= ScrH) bottom = ScrH - 1;
        left   = center - half;
        if (left < 0) left = 0;
        right  = center + half;
        if (right >= ScrW) right = ScrW - 1;
        r.visible    = 1'b1;
        r.center_col = (center > 32767) ? 16'sh7FFF :
                       (center < -32768) ? 16'sh8000 : center[15:0];
        r.span_size  = (span > 65535) ? 16'hFFFF : span[15:0];
        r.top_row    = top[8:0];
        r.bottom_row = bottom[9:0];
        r.left_col   = (left > 32767) ? 15'h7FFF : left[14:0];
        r.right_col  = (right > 32767) ? 16'sh7FFF :
                       (right < -32768) ? 16'sh8000 : right[15:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Register writes: only called with the pipe drained
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic signed [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CAM_POS_X:   cam_x = val;
            CFG_CAM_POS_Y:   cam_y = val;
            CFG_VIEW_DIR_X:  dir_x = val;
            CFG_VIEW_DIR_Y:  dir_y = val;
            CFG_CAM_PLANE_X: pln_x = val;
            CFG_CAM_PLANE_Y: pln_y = val;
            default: ;                      // unknown index, block ignores it
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_camera(input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] ux, input logic signed [31:0] uy,
            input logic signed [31:0] vx, input logic signed [31:0] vy);
        write_reg(CFG_CAM_POS_X, px);
        write_reg(CFG_CAM_POS_Y, py);
        write_reg(CFG_VIEW_DIR_X, ux);
        write_reg(CFG_VIEW_DIR_Y, uy);
        write_reg(CFG_CAM_PLANE_X, vx);
        write_reg(CFG_CAM_PLANE_Y, vy);
    endtask

    task automatic wait_drained();
        while (pending_proj.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Input side: one transfer, optional idle burst after it
    // ---------------------------------------------------------------
    task automatic send_sprite(input logic signed [31:0] sx, input logic signed [31:0] sy,
            input bit typed, input t_out_item typed_res);
        t_in_item  item;
        t_out_item expd;
        int        gap;
        item.sprite_x = sx;
        item.sprite_y = sy;
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do @(posedge clk); while (!in_ch.ready);
        expd = project_sprite(sx, sy);
        if (typed && expd !== typed_res) begin
            $error("directed row disagrees with predictor: typed %h predicted %h",
                   typed_res, expd);
            errors++;
        end
        pending_proj.push_back(typed ? typed_res : expd);
        n_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_q(input int units);
        return $signed($urandom_range(0, 2 * units * 65536)) - units * 65536;
    endfunction

    function automatic logic signed [31:0] rand_sprite(input logic signed [31:0] base);
        if ($urandom_range(0, 4) == 0) return $urandom;    // whole 32-bit range
        return clamp_q(66'(longint'(base) + longint'(rand_q(16))));
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall bursts, compare each transfer
    // ---------------------------------------------------------------
    int stall_left;
    always @(negedge clk) begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rdy = 1'b0;
        end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            rdy = 1'b0;
        end
        out_ch.ready <= rdy;
    end

    always @(posedge clk) begin
        t_out_item got, want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            n_seen++;
            if (pending_proj.size() == 0) begin
                $error("output transfer with nothing pending: %h", got);
                errors++;
            end else begin
                want = pending_proj.pop_front();
                if (got.visible)   n_visible++;
                if (got.visible !== want.visible) begin
                    $error("visible: expected %0d, got %0d", want.visible, got.visible);
                    errors++;
                end
                if (got.center_col !== want.center_col) begin
                    $error("center_col: expected %0d, got %0d", want.center_col,
                           got.center_col);
                    errors++;
                end
                if (got.span_size !== want.span_size) begin
                    $error("span_size: expected %0d, got %0d", want.span_size, got.span_size);
                    errors++;
                end
                if (got.top_row !== want.top_row) begin
                    $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
                    errors++;
                end
                if (got.bottom_row !== want.bottom_row) begin
                    $error("bottom_row: expected %0d, got %0d", want.bottom_row,
                           got.bottom_row);
                    errors++;
                end
                if (got.left_col !== want.left_col) begin
                    $error("left_col: expected %0d, got %0d", want.left_col, got.left_col);
                    errors++;
                end
                if (got.right_col !== want.right_col) begin
                    $error("right_col: expected %0d, got %0d", want.right_col, got.right_col);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d projections pending", cycles,
                     pending_proj.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed rows: positions under the reset camera
    // (dir 1.0,0 and plane 0,0.66). Rows flagged typed carry a result
    // worked out by hand; the rest go through the predictor.
    // ---------------------------------------------------------------
    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        bit                 typed;
        t_out_item          res;
    } t_row;

    initial begin
        t_row      rows[$];
        t_row      row;
        t_out_item hit;
        int        ph, k, per_phase;
        logic signed [31:0] ux, uy;

        errors = 0; cycles = 0; n_sent = 0; n_seen = 0; n_visible = 0;
        quiet = 1'b0; stall_left = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
        cam_x = 0; cam_y = 0; dir_x = QOne; dir_y = 0; pln_x = 0; pln_y = 32'sd43254;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sprite on the camera: zero depth, invisible
        row = '{sx: 0, sy: 0, typed: 1, res: '0};
        rows.push_back(row);
        // two units straight ahead: centered, 384 pixels
        hit = '{visible: 1'b1, center_col: 16'sd512, span_size: 16'd384, top_row: 9'd192,
                bottom_row: 10'd576, left_col: 15'd320, right_col: 16'sd704};
        row = '{sx: 2 * QOne, sy: 0, typed: 1, res: hit};
        rows.push_back(row);
        // two units behind: invisible
        row = '{sx: -2 * QOne, sy: 0, typed: 1, res: '0};
        rows.push_back(row);
        // depth right at and just past the near limit
        row = '{sx: 32'sd655, sy: 0, typed: 0, res: '0};
        rows.push_back(row);
        row = '{sx: 32'sd700, sy: 0, typed: 0, res: '0};
        rows.push_back(row);
        // extremes of both fields
        row = '{sx: QMax, sy: QMax, typed: 0, res: '0}; rows.push_back(row);
        row = '{sx: QMin, sy: QMin, typed: 0, res: '0}; rows.push_back(row);
        row = '{sx: QMax, sy: QMin, typed: 0, res: '0}; rows.push_back(row);
        row = '{sx: QMin, sy: QMax, typed: 0, res: '0}; rows.push_back(row);
        row = '{sx: QMax, sy: 0, typed: 0, res: '0};    rows.push_back(row);
        // close and far off axis: clamped bounds, saturated columns
        row = '{sx: QOne / 16, sy: QOne / 2, typed: 0, res: '0};  rows.push_back(row);
        row = '{sx: QOne / 64, sy: -QOne, typed: 0, res: '0};     rows.push_back(row);
        row = '{sx: QOne, sy: 32'sd3 * QOne, typed: 0, res: '0};  rows.push_back(row);
        row = '{sx: 32'sd1000 * QOne, sy: QOne, typed: 0, res: '0}; rows.push_back(row);
        row = '{sx: 32'sd40 * QOne, sy: -32'sd100 * QOne, typed: 0, res: '0};
        rows.push_back(row);
        row = '{sx: 32'sd1, sy: 32'sd1, typed: 0, res: '0};      rows.push_back(row);

        @(negedge clk);
        foreach (rows[i]) send_sprite(rows[i].sx, rows[i].sy, rows[i].typed, rows[i].res);
        in_ch.valid <= 1'b0;
        wait_drained();

        // singular camera: every sprite invisible
        load_camera(0, 0, QOne, 0, 2 * QOne, 0);
        @(negedge clk);
        send_sprite(2 * QOne, 0, 1'b1, '0);
        send_sprite(QMin, QMax, 1'b1, '0);
        in_ch.valid <= 1'b0;
        wait_drained();

        // Random phases. Phase 0 and 1 use register extremes; the rest a
        // random camera of moderate size. Unknown indexes are poked too.
        per_phase = RandItems / 7;
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: load_camera(QMax, QMin, QMax, QMin, QMax, QMax);
                1: load_camera(QMin, QMax, QMin, QMax, QMin, QMin);
                default: begin
                    ux = rand_q(2);
                    uy = rand_q(2);
                    load_camera(rand_q(64), rand_q(64), ux, uy,
                                $urandom_range(0, 1) ? -(uy * 2 / 3) : rand_q(2),
                                $urandom_range(0, 1) ? (ux * 2 / 3) : rand_q(2));
                end
            endcase
            write_reg(ph[0] ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
            @(negedge clk);
            for (k = 0; k < per_phase; k++) begin
                if (ph == 6 && k >= per_phase - QuietTail) quiet = 1'b1;
                send_sprite(rand_sprite(cam_x), rand_sprite(cam_y), 1'b0, '0);
            end
            in_ch.valid <= 1'b0;
            if (ph != 6) wait_drained();
        end

        while (pending_proj.size() != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        $display("%0d sprites projected over 9 camera settings, %0d of them visible",
                 n_sent, n_visible);
        $display("%0d result transfers checked, %0d mismatches", n_seen, errors);
        if (errors == 0 && pending_proj.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
